@@ rtl/fnd_pkg.sv @@
// Shared constants, types and constant tables of the folded normal density unit.
`default_nettype none
package fnd_pkg;

    localparam int EXP_TABLE_BITS = 8;
    localparam int LOG_TABLE_BITS = 8;
    localparam int EXP_SIZE       = 1 << EXP_TABLE_BITS;
    localparam int LOG_SIZE       = 1 << LOG_TABLE_BITS;
    localparam int REM_W          = 16 - EXP_TABLE_BITS;

    localparam logic [22:0] ARG_CAP   = 23'd4194304;   // 64.0 in Q16.16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [16:0] LN2_Q16   = 17'd45426;
    localparam logic [63:0] TINY_Q62  = 64'd46116;
    localparam logic [31:0] ONE_Q31   = 32'h8000_0000;

    // Stage positions; stage 0 is the input register.
    localparam int G_LAT     = 7;
    localparam int L_LAT     = 8;
    localparam int U_STAGE   = G_LAT + 1;
    localparam int LOG_DONE  = U_STAGE + L_LAT;
    localparam int OUT_STAGE = LOG_DONE + 1;

    typedef enum logic [1:0] {
        CFG_MEAN,
        CFG_INV_TWO_VAR,
        CFG_INV_NORM,
        CFG_LOG_NORM
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_NEG    = 2'd1,
        ST_TINY   = 2'd2
    } t_status;

    typedef logic [31:0] t_exp_tab [EXP_SIZE];
    typedef logic [16:0] t_log_tab [LOG_SIZE + 1];

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > v) b = b >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Entry i is 2^(-i/EXP_SIZE) in Q31, from products of repeated square roots.
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [63:0] root [16];
        logic [63:0] p;
        logic [15:0] fr;
        root[0] = isqrt64(64'd1 << 61);
        for (int k = 1; k < 16; k++) root[k] = isqrt64(root[k-1] << 31);
        for (int i = 0; i < EXP_SIZE; i++) begin
            fr = 16'(i << REM_W);
            p  = 64'(ONE_Q31);
            for (int k = 0; k < 16; k++) begin
                if (fr[15-k]) p = (p * root[k]) >> 31;
            end
            tab[i] = p[31:0];
        end
        return tab;
    endfunction

    // Entry i is log2(1 + i/LOG_SIZE) in Q16, by repeated squaring.
    function automatic t_log_tab build_log_tab();
        t_log_tab    tab;
        logic [63:0] v;
        logic [16:0] res;
        for (int i = 0; i < LOG_SIZE; i++) begin
            v   = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
            res = '0;
            for (int k = 1; k <= 16; k++) begin
                v = (v * v) >> 30;
                if (v >= (64'd2 << 30)) begin
                    v = v >> 1;
                    res[16-k] = 1'b1;
                end
            end
            tab[i] = res;
        end
        tab[LOG_SIZE] = 17'd65536;
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();
    localparam t_log_tab LOG_TAB = build_log_tab();

endpackage
`default_nettype wire

@@ rtl/folded_normal_density_unit.sv @@
// Top level of the folded normal density unit: config, pipeline control and output.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  sample  | in        | i_valid / o_stall    | i_sample
//  result  | out       | o_valid / i_stall    | o_density_out, o_log_density_out, o_status
//  config  | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One request per cycle unless the output stalls; each result passes the input register
// and the exponent, log and output stages. Synchronous active-low reset clears the valid
// bits and loads the register defaults. A stalled output holds the whole pipeline.
`default_nettype none
module folded_normal_density_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_sample,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [31:0] o_density_out,
    output logic      [31:0] o_log_density_out,
    output logic      [1:0]  o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import fnd_pkg::*;

    localparam int DENS_STAGE = U_STAGE + 2;

    logic [31:0] r_mean;
    logic [31:0] r_inv_two_var;
    logic [31:0] r_inv_norm;
    logic [31:0] r_log_norm;

    logic [OUT_STAGE:0] r_vld;
    logic [LOG_DONE:0]  r_neg;
    logic [31:0]        r_mag1;
    logic [31:0]        r_mag2;
    logic [63:0]        r_u;
    logic [64:0]        r_dt;
    logic [31:0]        r_dq;
    logic               r_tiny   [U_STAGE+1:LOG_DONE];
    logic [31:0]        r_dens   [DENS_STAGE:LOG_DONE];
    logic [31:0]        r_o_dens;
    logic [31:0]        r_o_log;
    t_status            r_o_status;

    logic               adv;
    logic signed [32:0] d1;
    logic signed [32:0] d2;
    logic [31:0]        n_mag1;
    logic [31:0]        n_mag2;
    logic [63:0]        term1;
    logic [63:0]        term2;
    logic [62:0]        lo_prod;
    logic [34:0]        dens_sum;
    logic [31:0]        n_dens;
    logic [31:0]        log_val;

    assign adv     = !(r_vld[OUT_STAGE] && i_stall);
    assign o_stall = !adv;

    always_comb begin
        d1     = $signed({i_sample[31], i_sample}) - $signed({r_mean[31], r_mean});
        d2     = $signed({i_sample[31], i_sample}) + $signed({r_mean[31], r_mean});
        n_mag1 = d1[32] ? 32'(-d1) : d1[31:0];
        n_mag2 = d2[32] ? 32'(-d2) : d2[31:0];
        lo_prod  = 63'(r_u[30:0]) * 63'(r_inv_norm);
        dens_sum = 35'(r_dt[64:31]) + 35'((33'(r_dt[30:0]) + 33'(r_dq)) >> 31);
        n_dens   = (dens_sum > 35'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : dens_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean        <= 32'd0;
            r_inv_two_var <= 32'd32768;
            r_inv_norm    <= 32'd26145;
            r_log_norm    <= 32'd60224;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MEAN:        r_mean        <= i_cfg_data;
                CFG_INV_TWO_VAR: r_inv_two_var <= i_cfg_data;
                CFG_INV_NORM:    r_inv_norm    <= i_cfg_data;
                CFG_LOG_NORM:    r_log_norm    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[OUT_STAGE-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_neg  <= {r_neg[LOG_DONE-1:0], i_sample[31]};
            r_mag1 <= n_mag1;
            r_mag2 <= n_mag2;
            r_u    <= term1 + term2;
            r_dt   <= 65'(r_u[63:31]) * 65'(r_inv_norm);
            r_dq   <= lo_prod[62:31];
            r_tiny[U_STAGE+1] <= (r_u <= TINY_Q62);
            for (int i = U_STAGE + 2; i <= LOG_DONE; i++) r_tiny[i] <= r_tiny[i-1];
            r_dens[DENS_STAGE] <= n_dens;
            for (int i = DENS_STAGE + 1; i <= LOG_DONE; i++) r_dens[i] <= r_dens[i-1];
            if (r_neg[LOG_DONE]) begin
                r_o_dens   <= 32'd0;
                r_o_log    <= 32'h8000_0000;
                r_o_status <= ST_NEG;
            end else if (r_tiny[LOG_DONE]) begin
                r_o_dens   <= r_dens[LOG_DONE];
                r_o_log    <= 32'h8000_0000;
                r_o_status <= ST_TINY;
            end else begin
                r_o_dens   <= r_dens[LOG_DONE];
                r_o_log    <= log_val;
                r_o_status <= ST_NORMAL;
            end
        end
    end

    fnd_gauss u_gauss_lo (
        .i_clk         (i_clk),
        .i_en          (adv),
        .i_mag         (r_mag1),
        .i_inv_two_var (r_inv_two_var),
        .o_term        (term1)
    );

    fnd_gauss u_gauss_hi (
        .i_clk         (i_clk),
        .i_en          (adv),
        .i_mag         (r_mag2),
        .i_inv_two_var (r_inv_two_var),
        .o_term        (term2)
    );

    fnd_log u_log (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_u        (r_u),
        .i_log_norm (r_log_norm),
        .o_log      (log_val)
    );

    assign o_valid           = r_vld[OUT_STAGE];
    assign o_density_out     = r_o_dens;
    assign o_log_density_out = r_o_log;
    assign o_status          = r_o_status;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    a_neg_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NEG) |-> (o_density_out == 32'd0
            && o_log_density_out == 32'h8000_0000))
        else $error("negative sample result malformed");

    a_tiny_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_TINY) |-> (o_log_density_out == 32'h8000_0000))
        else $error("tiny value result malformed");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_vld[OUT_STAGE-1]) |=> !o_valid)
        else $error("result appeared without a request in flight");

endmodule
`default_nettype wire

@@ rtl/fnd_gauss.sv @@
// Pipelined Gaussian term exp(-d^2 * inv_two_var) in Q2.62.
`default_nettype none
module fnd_gauss (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_mag,
    input  wire logic [31:0] i_inv_two_var,
    output logic      [63:0] o_term
);
    import fnd_pkg::*;

    logic [63:0] r_sq;
    logic [63:0] r_hp;
    logic [31:0] r_lp;
    logic [22:0] r_arg;
    logic [39:0] r_yp;
    logic [31:0] r_tab;
    logic [31:0] r_corr;
    logic [6:0]  r_n5;
    logic [6:0]  r_n6;
    logic [31:0] r_mant;
    logic [63:0] r_term;

    logic [63:0] lo_prod;
    logic [63:0] sum;
    logic [22:0] n_arg;
    logic [15:0] frac;
    logic [6:0]  shift_n;
    logic [27:0] rem_prod;
    logic [63:0] mant_prod;
    logic [63:0] n_term;

    always_comb begin
        lo_prod = r_sq[31:0] * i_inv_two_var;
        sum     = r_hp + {32'd0, r_lp};
        if (r_hp >= 64'(ARG_CAP)) begin
            n_arg = ARG_CAP;
        end else if (sum > 64'(ARG_CAP)) begin
            n_arg = ARG_CAP;
        end else begin
            n_arg = sum[22:0];
        end
        shift_n   = r_yp[38:32];
        frac      = r_yp[31:16];
        rem_prod  = 28'(frac[REM_W-1:0]) * 28'(LN2_Q16);
        mant_prod = 64'(r_tab) * 64'(r_corr);
        if (r_n6 >= 7'd63) begin
            n_term = '0;
        end else begin
            n_term = {1'b0, r_mant, 31'd0} >> r_n6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq   <= 64'(i_mag) * 64'(i_mag);
            r_hp   <= 64'(r_sq[63:32]) * 64'(i_inv_two_var);
            r_lp   <= lo_prod[63:32];
            r_arg  <= n_arg;
            r_yp   <= 40'(r_arg) * 40'(LOG2E_Q16);
            r_tab  <= EXP_TAB[frac[15 -: EXP_TABLE_BITS]];
            r_corr <= ONE_Q31 - 32'(rem_prod >> 1);
            r_n5   <= shift_n;
            r_mant <= mant_prod[62:31];
            r_n6   <= r_n5;
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule
`default_nettype wire

@@ rtl/fnd_log.sv @@
// Pipelined natural log of a Q2.62 value minus the log normalizer, saturated Q16.16.
`default_nettype none
module fnd_log (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_u,
    input  wire logic [31:0] i_log_norm,
    output logic      [31:0] o_log
);
    import fnd_pkg::*;

    logic [7:0]                r_nz;
    logic [2:0]                r_pos [8];
    logic [63:0]               r_u1;
    logic [5:0]                r_p2;
    logic [63:0]               r_u2;
    logic [LOG_TABLE_BITS-1:0] r_idx;
    logic [15:0]               r_r16;
    logic [5:0]                r_p3;
    logic [16:0]               r_diff;
    logic [16:0]               r_lo;
    logic [15:0]               r_r16b;
    logic [5:0]                r_p4;
    logic [16:0]               r_frac;
    logic signed [25:0]        r_base;
    logic signed [25:0]        r_l2;
    logic signed [43:0]        r_lp;
    logic [31:0]               r_log;

    logic [7:0]         n_nz;
    logic [2:0]         n_pos [8];
    logic [5:0]         n_p;
    logic [63:0]        w;
    logic [16:0]        tab_lo;
    logic [16:0]        tab_hi;
    logic [32:0]        frac_prod;
    logic signed [7:0]  p_off;
    logic signed [33:0] lg;
    logic [31:0]        n_log;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            n_nz[b]  = |i_u[8*b +: 8];
            n_pos[b] = '0;
            for (int j = 0; j < 8; j++) begin
                if (i_u[8*b + j]) n_pos[b] = 3'(j);
            end
        end
        n_p = '0;
        for (int b = 0; b < 8; b++) begin
            if (r_nz[b]) n_p = {3'(b), r_pos[b]};
        end
        // Place the leading one at bit 63; the mantissa fraction follows it.
        w         = r_u2 << (6'd63 - r_p2);
        tab_lo    = LOG_TAB[r_idx];
        tab_hi    = LOG_TAB[{1'b0, r_idx} + 1'b1];
        frac_prod = 33'(r_diff) * 33'(r_r16b);
        p_off     = $signed({2'b00, r_p4}) - 8'sd62;
        lg        = 34'(r_lp >>> 16) - 34'($signed(i_log_norm));
        if (lg > 34'sh0_7FFF_FFFF) begin
            n_log = 32'h7FFF_FFFF;
        end else if (lg < -34'sh0_8000_0000) begin
            n_log = 32'h8000_0000;
        end else begin
            n_log = lg[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nz   <= n_nz;
            r_pos  <= n_pos;
            r_u1   <= i_u;
            r_p2   <= n_p;
            r_u2   <= r_u1;
            r_idx  <= w[62 -: LOG_TABLE_BITS];
            r_r16  <= w[62-LOG_TABLE_BITS -: 16];
            r_p3   <= r_p2;
            r_diff <= tab_hi - tab_lo;
            r_lo   <= tab_lo;
            r_r16b <= r_r16;
            r_p4   <= r_p3;
            r_frac <= frac_prod[32:16];
            r_base <= $signed({{2{p_off[7]}}, p_off, 16'd0}) + $signed({9'd0, r_lo});
            r_l2   <= r_base + $signed({9'd0, r_frac});
            r_lp   <= 44'(r_l2) * $signed({1'b0, LN2_Q16});
            r_log  <= n_log;
        end
    end

    assign o_log = r_log;

endmodule
`default_nettype wire
